/* sv/ccrc_pkg.sv */
// shared types, constants and the crc byte update for the chunked crc-32c core
package ccrc_pkg;

	localparam int unsigned DATA_W      = 8;
	localparam int unsigned CRC_W       = 32;
	localparam int unsigned SIZE_W      = 25;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [SIZE_W-1:0] CHUNK_SIZE_RESET = SIZE_W'(16384);
	localparam logic [SIZE_W-1:0] CHUNK_MAX_BYTES  = SIZE_W'(16777216);
	localparam logic [CRC_W-1:0]  CRC_POLY_REFL    = 32'h82F6_3B78;
	localparam logic [CRC_W-1:0]  CRC_ALL_ONES     = 32'hFFFF_FFFF;

	// one classified byte on its way from front to back
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              close;
		logic              last;
	} entry_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// reflected crc-32c, one byte lsb first, unrolled into an xor network
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
	                                              input logic [DATA_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
		for (int k = 0; k < DATA_W; k++) begin
			c = c[0] ? (CRC_POLY_REFL ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* sv/ccrc_front.sv */
// front end: accepts bytes, counts chunk length and marks chunk closes
module ccrc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [ccrc_pkg::SIZE_W-1:0] cfg_data,
	input  logic                        in_valid,
	input  logic [ccrc_pkg::DATA_W-1:0] in_data,
	input  logic                        in_last,
	input  ccrc_pkg::qstat_t            qstat,
	output logic                        in_ready,
	output logic                        push,
	output ccrc_pkg::entry_t            push_entry
);

	logic [ccrc_pkg::SIZE_W-1:0] chunk_size_q;
	logic [ccrc_pkg::SIZE_W-1:0] bytes_q;
	logic [ccrc_pkg::SIZE_W-1:0] eff_size;
	logic [ccrc_pkg::SIZE_W:0]   count;
	logic                        close;

	always_comb begin
		if (chunk_size_q == '0) begin
			eff_size = ccrc_pkg::SIZE_W'(1);
		end else if (chunk_size_q > ccrc_pkg::CHUNK_MAX_BYTES) begin
			eff_size = ccrc_pkg::CHUNK_MAX_BYTES;
		end else begin
			eff_size = chunk_size_q;
		end
	end

	assign count    = {1'b0, bytes_q} + (ccrc_pkg::SIZE_W+1)'(1);
	assign close    = in_last || (count >= {1'b0, eff_size});
	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	assign push_entry.data  = in_data;
	assign push_entry.close = close;
	assign push_entry.last  = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= ccrc_pkg::CHUNK_SIZE_RESET;
			bytes_q      <= '0;
		end else begin
			if (cfg_valid) begin
				chunk_size_q <= cfg_data;
			end
			if (push) begin
				bytes_q <= close ? '0 : count[ccrc_pkg::SIZE_W-1:0];
			end
		end
	end

	// an open chunk never reaches the largest chunk size
	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q < ccrc_pkg::CHUNK_MAX_BYTES)
		else $error("open chunk count out of range");

endmodule

/* sv/ccrc_queue.sv */
// short fifo of classified bytes between front and back
module ccrc_queue #(
	parameter int unsigned DEPTH = ccrc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ccrc_pkg::entry_t push_entry,
	input  logic             pop,
	output ccrc_pkg::entry_t head,
	output ccrc_pkg::qstat_t qstat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ccrc_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && qstat.full) |-> pop)
		else $error("push into full queue");

endmodule

/* sv/ccrc_back.sv */
// back end: crc update per byte and the registered checksum output
module ccrc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ccrc_pkg::entry_t           head,
	input  ccrc_pkg::qstat_t           qstat,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ccrc_pkg::CRC_W-1:0] out_checksum,
	output logic                       out_final
);

	logic [ccrc_pkg::CRC_W-1:0] crc_q;
	logic [ccrc_pkg::CRC_W-1:0] crc_next;
	logic [ccrc_pkg::CRC_W-1:0] checksum_q;
	logic                       final_q;
	logic                       valid_q;

	assign crc_next = ccrc_pkg::crc_byte(crc_q, head.data);
	// a closing byte waits only while an untaken checksum sits in the output
	assign pop      = !qstat.empty && (!head.close || !valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= ccrc_pkg::CRC_ALL_ONES;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				crc_q <= head.close ? ccrc_pkg::CRC_ALL_ONES : crc_next;
			end
			if (pop && head.close) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.close) begin
			checksum_q <= ~crc_next;
			final_q    <= head.last;
		end
	end

	assign out_valid    = valid_q;
	assign out_checksum = checksum_q;
	assign out_final    = final_q;

	// a stalled checksum is never overwritten by the next chunk close
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |-> !(pop && head.close))
		else $error("checksum overwritten while stalled");

	// the crc restarts from all ones after every chunk close
	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.close) |=> (crc_q == ccrc_pkg::CRC_ALL_ONES))
		else $error("crc not restarted after chunk close");

endmodule

/* sv/chunked_crc32c_checksum_core.sv */
// top level of the chunked crc-32c checksum core
//
// channel  dir  handshake                     payload
// s_*      in   s_tvalid / s_tready           s_tdata[7:0] data_byte, s_tlast end_of_data
// m_*      out  m_tvalid / m_tready           m_tdata[31:0] checksum, m_tlast final_chunk
// cfg_*    in   cfg_valid / cfg_ready (hi)    cfg_data[24:0] chunk_size
//
// one byte per cycle sustained while the queue has room; the crc update is a combinational xor network in the back end
// a byte reaches the crc through the queue write, then the back-end update
// a checksum shows on m_* the cycle after its closing byte leaves the queue
// reset clears the chunk count, the crc (all ones), the queue and the output; chunk_size
// returns to 16384
// an m_* stall holds only a closing byte; the queue keeps taking bytes until it is full
module chunked_crc32c_checksum_core #(
	parameter int unsigned QUEUE_DEPTH = ccrc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_data
	// checksum stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] checksum
	output logic        m_tlast,   // final_chunk
	// chunk size register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [24:0] cfg_data   // [24:0] chunk_size
);

	ccrc_pkg::entry_t push_entry;
	ccrc_pkg::entry_t head;
	ccrc_pkg::qstat_t qstat;
	logic             push;
	logic             pop;

	// the register is always writable
	assign cfg_ready = 1'b1;

	// front: count bytes, decide where each chunk closes
	ccrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_data    (s_tdata),
		.in_last    (s_tlast),
		.qstat      (qstat),
		.in_ready   (s_tready),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue so the output stall does not stop intake at once
	ccrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// back: crc of the open chunk and the registered result
	ccrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_checksum (m_tdata),
		.out_final    (m_tlast)
	);

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the chunked crc-32c checksum core
module tb;

	import ccrc_pkg::*;

	localparam int SETTLE      = 8;        // cycles for a byte to clear the queue and crc stage
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_MAX    = 10;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;
	typedef enum logic [1:0] {PACE_STEADY, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_e;

	typedef struct packed {
		logic [31:0] sum;
		logic        final_flag;
	} chunk_sum_t;

	// one line of the directed table: a byte transaction or a chunk size write
	typedef struct packed {
		row_kind_e         kind;
		logic [SIZE_W-1:0] value;
		logic              last;
		logic              known;
		logic [31:0]       sum;
	} plan_row_t;

	localparam int PLAN_ROWS = 26;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [24:0] cfg_data = 25'd0;

	// predictor state
	logic [31:0]       model_crc = CRC_ALL_ONES;
	logic [SIZE_W-1:0] model_fill = '0;
	logic [SIZE_W-1:0] model_size = CHUNK_SIZE_RESET;

	chunk_sum_t pending_sums[$];
	int         mismatches = 0;
	int         cycles = 0;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	plan_row_t  plan [PLAN_ROWS];

	chunked_crc32c_checksum_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// bit-serial form of the reflected crc: feedback is crc lsb xor data bit
	function automatic logic [31:0] crc32c_fold_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY_REFL;
			end
		end
		return c;
	endfunction

	// advance the chunk model by one byte; closed says a checksum falls out
	task automatic absorb_byte(input logic [7:0] b, input logic last,
	                           output logic closed, output chunk_sum_t res);
		logic [SIZE_W:0]   count;
		logic [SIZE_W-1:0] limit;
		model_crc = crc32c_fold_byte(model_crc, b);
		count     = {1'b0, model_fill} + (SIZE_W+1)'(1);
		if (model_size == '0) begin
			limit = SIZE_W'(1);
		end else if (model_size > CHUNK_MAX_BYTES) begin
			limit = CHUNK_MAX_BYTES;
		end else begin
			limit = model_size;
		end
		closed         = last || (count >= {1'b0, limit});
		res.sum        = ~model_crc;
		res.final_flag = last;
		if (closed) begin
			model_crc  = CRC_ALL_ONES;
			model_fill = '0;
		end else begin
			model_fill = count[SIZE_W-1:0];
		end
	endtask

	// one byte transaction with random sender gaps; known overrides the predicted checksum
	task automatic send_byte(input logic [7:0] b, input logic last,
	                         input logic known, input logic [31:0] sum);
		logic       closed;
		chunk_sum_t res;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		absorb_byte(b, last, closed, res);
		if (known) begin
			res.sum = sum;
		end
		if (closed) begin
			pending_sums.push_back(res);
		end
	endtask

	// hold the sender until every predicted checksum has come out
	task automatic drain_sums();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_sums.size() != 0);
	endtask

	task automatic write_chunk_size(input logic [SIZE_W-1:0] v);
		drain_sums();
		// a byte that closes nothing may still sit in the pipe
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		model_size = v;
	endtask

	// sink side stalls
	always @(posedge clk) begin
		m_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
	end

	// checksum transactions against the oldest prediction
	always @(posedge clk) begin
		chunk_sum_t want;
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d checksums outstanding",
			         cycles, pending_sums.size());
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX) begin
					$display("%0t: unexpected checksum %h last %0b", $time, m_tdata, m_tlast);
				end
			end else begin
				want = pending_sums.pop_front();
				if (m_tdata !== want.sum || m_tlast !== want.final_flag) begin
					mismatches++;
					if (mismatches <= SHOW_MAX) begin
						$display("%0t: checksum expected %h last %0b, got %h last %0b",
						         $time, want.sum, want.final_flag, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	initial begin
		int                ph;
		int                sent;
		int                len;
		logic [SIZE_W-1:0] size_pick;
		logic              last;

		plan = '{
			// standard check string "123456789" under the reset chunk size
			'{ROW_BYTE, 25'h31, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h32, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h33, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h34, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h35, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h36, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h37, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h38, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h39, 1'b1, 1'b1, 32'hE306_9283},
			// size zero behaves as one byte per chunk
			'{ROW_CFG,  25'h0000000, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h00, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'hFF, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'hA5, 1'b1, 1'b0, 32'h0},
			// all ones saturates to the largest chunk
			'{ROW_CFG,  25'h1FFFFFF, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h00, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'hFF, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h80, 1'b1, 1'b0, 32'h0},
			// shrink the size under an open chunk: next byte closes it
			'{ROW_CFG,  25'h0000003, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h12, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h34, 1'b0, 1'b0, 32'h0},
			'{ROW_CFG,  25'h0000001, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h56, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h01, 1'b1, 1'b0, 32'h0},
			// exact maximum chunk size
			'{ROW_CFG,  25'h1000000, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'hAA, 1'b0, 1'b0, 32'h0},
			'{ROW_BYTE, 25'h55, 1'b1, 1'b0, 32'h0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_chunk_size(plan[i].value);
			end else begin
				send_byte(plan[i].value[7:0], plan[i].last, plan[i].known, plan[i].sum);
			end
		end

		// random phases: each pace mode, small sizes mostly, the extremes now and then
		for (ph = 0; ph < 16; ph++) begin
			drain_sums();
			case (pace_e'(ph % 4))
				PACE_STEADY: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				PACE_SRC_IDLE: begin
					src_idle_pct   = 75;
					sink_stall_pct = 0;
				end
				PACE_SINK_STALL: begin
					src_idle_pct   = 0;
					sink_stall_pct = 75;
				end
				default: begin
					src_idle_pct   = 17;
					sink_stall_pct = 17;
				end
			endcase
			case (ph)
				3:       size_pick = '0;
				7:       size_pick = 25'h1FFFFFF;
				10:      size_pick = CHUNK_MAX_BYTES;
				13:      size_pick = CHUNK_SIZE_RESET;
				default: size_pick = SIZE_W'($urandom_range(1, (ph < 8) ? 6 : 40));
			endcase
			write_chunk_size(size_pick);
			sent = 0;
			// well-formed streams; the last one of a phase may stay open across the write
			while (sent < 96) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
				for (int k = 0; k < len && sent < 96; k++) begin
					last = (k == len - 1) || ($urandom_range(40) == 0);
					send_byte(8'($urandom_range(255)), last, 1'b0, 32'h0);
					sent++;
				end
				if ($urandom_range(15) == 0) begin
					drain_sums();
				end
			end
		end

		drain_sums();
		repeat (2 * SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_sums.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/ccrc_pkg.sv
sv/ccrc_front.sv
sv/ccrc_queue.sv
sv/ccrc_back.sv
sv/chunked_crc32c_checksum_core.sv
tb/sv/tb.sv
